/* design/csfd_pkg.sv */
// csfd_pkg: shared types, codes and reset constants for the composite-sync
// frame detector. No dependencies.
`default_nettype none

package csfd_pkg;

  localparam int unsigned PulseW   = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PulseW-1:0] ShortPulseMaxRst = 16'd288;
  localparam logic [CountW-1:0] MinEqualizingRst = 8'd8;
  localparam logic [MsW-1:0]    TimeoutMsRst     = 16'd5000;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PULSE = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SEARCH  = 2'd1,
    PH_FOUND   = 2'd2,
    PH_TIMEOUT = 2'd3
  } phase_e;

  typedef enum logic [ModeW-1:0] {
    MODE_TWO_VSYNC  = 2'd0,
    MODE_ONE_VSYNC  = 2'd1,
    MODE_VSYNC_ONLY = 2'd2
  } mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SHORT_PULSE_MAX = 2'd0,
    CFG_MIN_EQUALIZING  = 2'd1,
    CFG_LIMIT_MS        = 2'd2,
    CFG_SEARCH_MODE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PulseW-1:0] short_pulse_max;
    logic [CountW-1:0] min_equalizing;
    logic [MsW-1:0]    limit_ms;
    logic [ModeW-1:0]  search_mode;
  } cfg_t;

endpackage

`default_nettype wire

/* design/composite_sync_frame_detector_unit.sv */
// composite_sync_frame_detector_unit: top level with input and result word
// registers around csfd_engine, plus csfd_cfg_regs. Depends on csfd_pkg.
//
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata[15:0] pulse_width, tuser[1:0] req_type
// m_axis    out  m_axis_tvalid/tready        tdata[1:0] status, tdata[7:2] zero
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_addr_i register index, cfg_data_i value
//
// One word accepted per cycle while s_axis_tready is high; each word is held in
// the input register, then its status word goes to the result word register.
// Throughput is set by the input register feeding the engine.
// Reset clears search state and loads register defaults; no clearing pass.
// A stalled m_axis holds the result word; the input register still takes one
// more word before s_axis_tready drops.
`default_nettype none

module composite_sync_frame_detector_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [15:0] pulse_width
  input  wire logic [1:0]                    s_axis_tuser,  // [1:0] req_type
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [7:0]                    m_axis_tdata,  // [1:0] status, [7:2] zero
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [csfd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [csfd_pkg::CfgDataW-1:0] cfg_data_i
);
  import csfd_pkg::*;

  cfg_t              cfg;
  logic              in_valid_q;
  logic [1:0]        req_q;
  logic [PulseW-1:0] width_q;
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [1:0]        status_d;
  logic              in_load;
  logic              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  csfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  csfd_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (advance),
    .req_i    (req_q),
    .width_i  (width_q),
    .status_o (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) in_valid_q <= 1'b1;
      else if (advance) in_valid_q <= 1'b0;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      req_q   <= s_axis_tuser;
      width_q <= s_axis_tdata;
    end
    if (advance) status_q <= status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, status_q};

endmodule

`default_nettype wire

/* design/csfd_cfg_regs.sv */
// csfd_cfg_regs: configuration register file written over the cfg channel.
// Depends on csfd_pkg.
`default_nettype none

module csfd_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [csfd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [csfd_pkg::CfgDataW-1:0] cfg_data_i,
  output      csfd_pkg::cfg_t                cfg_o
);
  import csfd_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_pulse_max <= ShortPulseMaxRst;
      cfg_q.min_equalizing  <= MinEqualizingRst;
      cfg_q.limit_ms        <= TimeoutMsRst;
      cfg_q.search_mode     <= MODE_TWO_VSYNC;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_SHORT_PULSE_MAX: cfg_q.short_pulse_max <= cfg_data_i[PulseW-1:0];
        CFG_MIN_EQUALIZING:  cfg_q.min_equalizing  <= cfg_data_i[CountW-1:0];
        CFG_LIMIT_MS:        cfg_q.limit_ms        <= cfg_data_i[MsW-1:0];
        CFG_SEARCH_MODE:     cfg_q.search_mode     <= cfg_data_i[ModeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/csfd_engine.sv */
// csfd_engine: search state (phase, stage, equalizing count, elapsed ms) and
// its next-state logic. Depends on csfd_pkg.
`default_nettype none

module csfd_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire csfd_pkg::cfg_t              cfg_i,
  input  wire logic                        fire_i,
  input  wire logic [1:0]                  req_i,
  input  wire logic [csfd_pkg::PulseW-1:0] width_i,
  output      logic [1:0]                  status_o
);
  import csfd_pkg::*;

  typedef enum logic [1:0] {
    ST_MARK1 = 2'd0,
    ST_MARK2 = 2'd1,
    ST_WIDE  = 2'd2
  } stage_e;

  phase_e            phase_q, phase_d;
  stage_e            stage_q, stage_d;
  logic [CountW-1:0] count_q, count_d;
  logic [MsW-1:0]    elapsed_q, elapsed_d;
  logic [MsW-1:0]    elapsed_inc;
  logic              searching;
  logic              two_vsync;

  assign searching   = (phase_q == PH_SEARCH);
  assign two_vsync   = (cfg_i.search_mode == MODE_TWO_VSYNC);
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + MsW'(1);

  always_comb begin
    phase_d   = phase_q;
    stage_d   = stage_q;
    count_d   = count_q;
    elapsed_d = elapsed_q;
    if (fire_i) begin
      unique case (req_e'(req_i))
        REQ_START: begin
          phase_d   = (cfg_i.limit_ms == '0) ? PH_TIMEOUT : PH_SEARCH;
          stage_d   = ST_MARK1;
          count_d   = '0;
          elapsed_d = '0;
        end
        REQ_PULSE: begin
          if (searching) begin
            priority if (elapsed_q >= cfg_i.limit_ms) begin
              phase_d = PH_TIMEOUT;
            end else if (width_i <= cfg_i.short_pulse_max) begin
              if (count_q != '1) count_d = count_q + CountW'(1);
            end else if (stage_q == ST_WIDE) begin
              phase_d = PH_FOUND;
            end else begin
              count_d = '0;
              if (count_q >= cfg_i.min_equalizing) begin
                priority if (stage_q == ST_MARK1 && two_vsync) begin
                  stage_d = ST_MARK2;
                end else if (two_vsync || cfg_i.search_mode == MODE_ONE_VSYNC) begin
                  stage_d = ST_WIDE;
                end else begin
                  phase_d = PH_FOUND;
                end
              end
            end
          end
        end
        REQ_TICK: begin
          if (searching) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= cfg_i.limit_ms) phase_d = PH_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      stage_q   <= ST_MARK1;
      count_q   <= '0;
      elapsed_q <= '0;
    end else begin
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
    end
  end

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(count_q) && $stable(elapsed_q))
    else $error("search state moved without an item");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i == REQ_START |=> count_q == '0 && elapsed_q == '0
                                     && stage_q == ST_MARK1 && phase_q != PH_IDLE)
    else $error("start did not reset the search");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SEARCH && !(fire_i && req_i == REQ_START) |=> $stable(phase_q))
    else $error("phase left a final state without a start");

  a_elapsed_only_searching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_SEARCH && !(fire_i && req_i == REQ_START) |=> $stable(elapsed_q))
    else $error("elapsed counter moved outside a search");

endmodule

`default_nettype wire
